### hw/rtl/dcp_pkg.sv
// shared constants, widths and pipeline record types of the distance constraint block
package dcp_pkg;

    // item formats
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ELAST_FRAC = 8;
    localparam int REST_W     = 31;
    localparam int ELAST_W    = 16;
    localparam int SHARE_W    = FRAC_BITS + 1;
    localparam int MINC_W     = 31;
    localparam logic [MINC_W-1:0] MIN_CORR_RESET = MINC_W'(655);

    // datapath widths
    localparam int CON_W   = COORD_BITS + 2;            // connector, signed
    localparam int MAG_W   = COORD_BITS + 2;            // connector magnitude
    localparam int HALF_W  = (MAG_W + 1) / 2;
    localparam int HI_W    = MAG_W - HALF_W;
    localparam int PH_W    = 2 * HALF_W;
    localparam int SQ_W    = 2 * MAG_W;                 // sum of squares
    localparam int ROOT_W  = MAG_W;                     // connector length
    localparam int ERR_W   = ROOT_W + 2;                // signed error
    localparam int EMAG_W  = ROOT_W + 1;
    localparam int EN_W    = EMAG_W + ELAST_FRAC;       // scaled error numerator
    localparam logic [ELAST_W-1:0] ELAST_ONE = ELAST_W'(1 << ELAST_FRAC);
    localparam int ESPL_W  = (EN_W + 1) / 2;
    localparam int PA_W    = ESPL_W + SHARE_W;
    localparam int PROD_W  = EN_W + SHARE_W;
    localparam int LEN_W   = PROD_W - FRAC_BITS;        // correction length
    localparam int LSPL_W  = (LEN_W + 1) / 2;
    localparam int PB_W    = MAG_W + LSPL_W;
    localparam int CN_W    = MAG_W + LEN_W;             // component numerator
    localparam int SUM_W   = LEN_W + 2;                 // displacement sum before clamp
    localparam int NCOMP   = 4;

    // total register stages from input to output register
    localparam int LAT = 10 + ROOT_W + EN_W + LEN_W;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] dax;
        logic signed [COORD_BITS-1:0] day;
        logic signed [COORD_BITS-1:0] dbx;
        logic signed [COORD_BITS-1:0] dby;
        logic signed [CON_W-1:0]      cx;
        logic signed [CON_W-1:0]      cy;
        logic [REST_W-1:0]            rest;
        logic [ELAST_W-1:0]           elast;
        logic [SHARE_W-1:0]           sa;
        logic [SHARE_W-1:0]           sb;
    } t_geo;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] dax;
        logic signed [COORD_BITS-1:0] day;
        logic signed [COORD_BITS-1:0] dbx;
        logic signed [COORD_BITS-1:0] dby;
        logic signed [CON_W-1:0]      cx;
        logic signed [CON_W-1:0]      cy;
        logic [SHARE_W-1:0]           sa;
        logic [SHARE_W-1:0]           sb;
        logic                         eneg;
        logic [ROOT_W-1:0]            root;
    } t_err;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] dax;
        logic signed [COORD_BITS-1:0] day;
        logic signed [COORD_BITS-1:0] dbx;
        logic signed [COORD_BITS-1:0] dby;
        logic [NCOMP-1:0]             neg;
        logic                         corr;
    } t_fix;

endpackage

### hw/rtl/dcp_if.sv
// item channels and configuration write channel of the distance constraint block
interface dcp_in_if;
    logic valid;
    logic ready;
    logic signed [dcp_pkg::COORD_BITS-1:0] pos_a_x;
    logic signed [dcp_pkg::COORD_BITS-1:0] pos_a_y;
    logic signed [dcp_pkg::COORD_BITS-1:0] disp_a_x;
    logic signed [dcp_pkg::COORD_BITS-1:0] disp_a_y;
    logic signed [dcp_pkg::COORD_BITS-1:0] pos_b_x;
    logic signed [dcp_pkg::COORD_BITS-1:0] pos_b_y;
    logic signed [dcp_pkg::COORD_BITS-1:0] disp_b_x;
    logic signed [dcp_pkg::COORD_BITS-1:0] disp_b_y;
    logic [dcp_pkg::REST_W-1:0]            rest_distance;
    logic [dcp_pkg::ELAST_W-1:0]           elasticity;
    logic [dcp_pkg::SHARE_W-1:0]           share_a;
    logic [dcp_pkg::SHARE_W-1:0]           share_b;

    modport source (output valid, output pos_a_x, output pos_a_y, output disp_a_x,
                    output disp_a_y, output pos_b_x, output pos_b_y, output disp_b_x,
                    output disp_b_y, output rest_distance, output elasticity,
                    output share_a, output share_b, input ready);
    modport sink (input valid, input pos_a_x, input pos_a_y, input disp_a_x,
                  input disp_a_y, input pos_b_x, input pos_b_y, input disp_b_x,
                  input disp_b_y, input rest_distance, input elasticity,
                  input share_a, input share_b, output ready);
endinterface

interface dcp_out_if;
    logic valid;
    logic ready;
    logic signed [dcp_pkg::COORD_BITS-1:0] new_disp_a_x;
    logic signed [dcp_pkg::COORD_BITS-1:0] new_disp_a_y;
    logic signed [dcp_pkg::COORD_BITS-1:0] new_disp_b_x;
    logic signed [dcp_pkg::COORD_BITS-1:0] new_disp_b_y;
    logic                                  corrected;

    modport source (output valid, output new_disp_a_x, output new_disp_a_y,
                    output new_disp_b_x, output new_disp_b_y, output corrected,
                    input ready);
    modport sink (input valid, input new_disp_a_x, input new_disp_a_y,
                  input new_disp_b_x, input new_disp_b_y, input corrected,
                  output ready);
endinterface

interface dcp_cfg_if;
    logic valid;
    logic ready;
    logic [dcp_pkg::MINC_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/dcp_div.sv
// pipelined restoring divider, one quotient bit per stage
module dcp_div #(
    parameter int N_W = dcp_pkg::EN_W,
    parameter int D_W = dcp_pkg::ELAST_W,
    parameter int Q_W = dcp_pkg::EN_W
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic [Q_W-1:0] o_quo
);
    // numerator bits above the quotient width must already be below the divisor
    logic [D_W-1:0] r_rem [Q_W];
    logic [Q_W-1:0] r_low [Q_W];
    logic [D_W-1:0] r_den [Q_W];
    logic [Q_W-1:0] r_quo [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [D_W-1:0] p_rem;
        logic [D_W-1:0] p_den;
        logic [Q_W-1:0] p_low;
        logic [Q_W-1:0] p_quo;
        logic [D_W:0]   s_try;
        logic [D_W:0]   s_diff;
        logic           n_bit;
        logic [D_W-1:0] n_rem;

        if (k == 0) begin : g_first
            assign p_rem = D_W'(i_num >> Q_W);
            assign p_low = i_num[Q_W-1:0];
            assign p_den = i_den;
            assign p_quo = '0;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_low = r_low[k-1];
            assign p_den = r_den[k-1];
            assign p_quo = r_quo[k-1];
        end

        always_comb begin
            s_try  = {p_rem, p_low[Q_W-1]};
            s_diff = s_try - {1'b0, p_den};
            n_bit  = (s_try >= {1'b0, p_den});
            n_rem  = n_bit ? s_diff[D_W-1:0] : s_try[D_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_low[k] <= p_low << 1;
                r_den[k] <= p_den;
                r_quo[k] <= {p_quo[Q_W-2:0], n_bit};
            end
        end
    end

    assign o_quo = r_quo[Q_W-1];
endmodule

### hw/rtl/distance_constraint_projection.sv
// top level: fully pipelined distance constraint projection between two point masses
//
// usage
//   i_item (valid/ready) takes one constraint item: positions and pending displacements
//   of masses a and b, rest distance, elasticity and the two correction shares.
//   o_res (valid/ready) returns one item per constraint: the two updated
//   displacements, each component clamped to the signed coordinate range, and a
//   corrected flag.
//   i_cfg (valid/ready) writes the correction threshold; it is always ready and
//   should only be written while no item is in flight.
// throughput and pipeline depth
//   one item per cycle while the output is not held; an item passes LAT register stages
//   from acceptance to the output register: the bit-per-stage square root (34 stages),
//   the elasticity divider (43 stages) and the four component dividers (44 stages).
// reset and stall
//   reset clears every valid bit and loads the threshold with 655 (about 0.01).
//   the whole pipe advances together: when the output item is held and not taken,
//   every stage holds, and i_item.ready drops in the same cycle. bubbles pass freely.
module distance_constraint_projection (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dcp_in_if.sink    i_item,
    dcp_cfg_if.sink   i_cfg,
    dcp_out_if.source o_res
);
    import dcp_pkg::*;

    // global advance: the output register is free or being emptied
    logic             en;
    logic [LAT-1:0]   r_vld;
    logic [MINC_W-1:0] r_min_corr;

    assign en           = !r_vld[LAT-1] || o_res.ready;
    assign i_item.ready = en;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_corr <= MIN_CORR_RESET;
        end else if (i_cfg.valid) begin
            r_min_corr <= i_cfg.data;
        end
    end

    // valid bits travel alongside the data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_item.valid};
        end
    end

    // stage 1: connector from predicted b to predicted a
    t_geo                    r1_geo;
    logic signed [CON_W-1:0] s1_cx;
    logic signed [CON_W-1:0] s1_cy;

    always_comb begin
        s1_cx = (CON_W'(i_item.pos_a_x) + CON_W'(i_item.disp_a_x))
              - (CON_W'(i_item.pos_b_x) + CON_W'(i_item.disp_b_x));
        s1_cy = (CON_W'(i_item.pos_a_y) + CON_W'(i_item.disp_a_y))
              - (CON_W'(i_item.pos_b_y) + CON_W'(i_item.disp_b_y));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_geo.dax   <= i_item.disp_a_x;
            r1_geo.day   <= i_item.disp_a_y;
            r1_geo.dbx   <= i_item.disp_b_x;
            r1_geo.dby   <= i_item.disp_b_y;
            r1_geo.cx    <= s1_cx;
            r1_geo.cy    <= s1_cy;
            r1_geo.rest  <= i_item.rest_distance;
            r1_geo.elast <= i_item.elasticity;
            r1_geo.sa    <= i_item.share_a;
            r1_geo.sb    <= i_item.share_b;
        end
    end

    // geometry carried through the squaring stages and the square root
    t_geo r_geo_d [ROOT_W+3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_geo_d[0] <= r1_geo;
            for (int k = 1; k < ROOT_W + 3; k++) begin
                r_geo_d[k] <= r_geo_d[k-1];
            end
        end
    end

    // stage 2: half-width partial products of each square
    logic [MAG_W-1:0] s2_mx;
    logic [MAG_W-1:0] s2_my;
    logic [PH_W-1:0]  r2_xhh, r2_xhl, r2_xll;
    logic [PH_W-1:0]  r2_yhh, r2_yhl, r2_yll;

    always_comb begin
        s2_mx = r1_geo.cx[CON_W-1] ? MAG_W'(-r1_geo.cx) : MAG_W'(r1_geo.cx);
        s2_my = r1_geo.cy[CON_W-1] ? MAG_W'(-r1_geo.cy) : MAG_W'(r1_geo.cy);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_xhh <= PH_W'(s2_mx[MAG_W-1:HALF_W]) * PH_W'(s2_mx[MAG_W-1:HALF_W]);
            r2_xhl <= PH_W'(s2_mx[MAG_W-1:HALF_W]) * PH_W'(s2_mx[HALF_W-1:0]);
            r2_xll <= PH_W'(s2_mx[HALF_W-1:0]) * PH_W'(s2_mx[HALF_W-1:0]);
            r2_yhh <= PH_W'(s2_my[MAG_W-1:HALF_W]) * PH_W'(s2_my[MAG_W-1:HALF_W]);
            r2_yhl <= PH_W'(s2_my[MAG_W-1:HALF_W]) * PH_W'(s2_my[HALF_W-1:0]);
            r2_yll <= PH_W'(s2_my[HALF_W-1:0]) * PH_W'(s2_my[HALF_W-1:0]);
        end
    end

    // stage 3: each square, stage 4: their sum
    logic [SQ_W-1:0] r3_xsq;
    logic [SQ_W-1:0] r3_ysq;
    logic [SQ_W-1:0] r4_sum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_xsq <= (SQ_W'(r2_xhh) << (2 * HALF_W)) + (SQ_W'(r2_xhl) << (HALF_W + 1))
                    + SQ_W'(r2_xll);
            r3_ysq <= (SQ_W'(r2_yhh) << (2 * HALF_W)) + (SQ_W'(r2_yhl) << (HALF_W + 1))
                    + SQ_W'(r2_yll);
            r4_sum <= r3_xsq + r3_ysq;
        end
    end

    // square root, one root bit per stage, floor result
    logic [ROOT_W:0]   r_sq_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_sq_root [ROOT_W];
    logic [SQ_W-1:0]   r_sq_rad  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        logic [ROOT_W:0]   p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [SQ_W-1:0]   p_rad;
        logic [ROOT_W+2:0] s_rem;
        logic [ROOT_W+2:0] s_try;
        logic [ROOT_W+2:0] s_diff;
        logic              s_fit;
        logic [ROOT_W:0]   n_rem;
        logic [ROOT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = r4_sum;
        end else begin : g_next
            assign p_rem  = r_sq_rem[k-1];
            assign p_root = r_sq_root[k-1];
            assign p_rad  = r_sq_rad[k-1];
        end

        always_comb begin
            s_rem  = {p_rem, p_rad[SQ_W-1 -: 2]};
            s_try  = {1'b0, p_root, 2'b01};
            s_diff = s_rem - s_try;
            s_fit  = (s_rem >= s_try);
            n_rem  = s_fit ? s_diff[ROOT_W:0] : s_rem[ROOT_W:0];
            n_root = {p_root[ROOT_W-2:0], s_fit};
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[k]  <= n_rem;
                r_sq_root[k] <= n_root;
                r_sq_rad[k]  <= p_rad << 2;
            end
        end
    end

    // error stage: length minus rest, scaled for the elasticity divider
    t_geo                    se_geo;
    logic [ROOT_W-1:0]       se_root;
    logic signed [ERR_W-1:0] se_err;
    logic                    se_eneg;
    logic [EMAG_W-1:0]       se_emag;
    t_err                    re_mid;
    logic [EN_W-1:0]         re_num;
    logic [ELAST_W-1:0]      re_den;

    always_comb begin
        se_geo  = r_geo_d[ROOT_W+2];
        se_root = r_sq_root[ROOT_W-1];
        se_err  = $signed(ERR_W'(se_root)) - $signed(ERR_W'(se_geo.rest));
        se_eneg = se_err[ERR_W-1];
        se_emag = EMAG_W'(se_eneg ? -se_err : se_err);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            re_mid.dax  <= se_geo.dax;
            re_mid.day  <= se_geo.day;
            re_mid.dbx  <= se_geo.dbx;
            re_mid.dby  <= se_geo.dby;
            re_mid.cx   <= se_geo.cx;
            re_mid.cy   <= se_geo.cy;
            re_mid.sa   <= se_geo.sa;
            re_mid.sb   <= se_geo.sb;
            re_mid.eneg <= se_eneg;
            re_mid.root <= se_root;
            re_num      <= EN_W'(se_emag) << ELAST_FRAC;
            // no elasticity: dividing the scaled error by one in q8.8 leaves it exact
            re_den      <= (se_geo.elast == '0) ? ELAST_ONE : se_geo.elast;
        end
    end

    // magnitude of the error over the elasticity, truncated
    logic [EN_W-1:0] w_q1;

    dcp_div #(
        .N_W (EN_W),
        .D_W (ELAST_W),
        .Q_W (EN_W)
    ) u_div_elast (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (re_num),
        .i_den (re_den),
        .o_quo (w_q1)
    );

    t_err r_mid_d [EN_W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mid_d[0] <= re_mid;
            for (int k = 1; k < EN_W; k++) begin
                r_mid_d[k] <= r_mid_d[k-1];
            end
        end
    end

    // threshold stage: correction decision and share partial products
    t_err            st_mid;
    t_err            rt_mid;
    logic            rt_corr;
    logic [PA_W-1:0] rt_alo, rt_ahi, rt_blo, rt_bhi;

    assign st_mid = r_mid_d[EN_W-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            rt_mid  <= st_mid;
            // zero-length connector never corrects
            rt_corr <= (st_mid.root != '0) && (w_q1 > EN_W'(r_min_corr));
            rt_alo  <= PA_W'(w_q1[ESPL_W-1:0]) * PA_W'(st_mid.sa);
            rt_ahi  <= PA_W'(w_q1[EN_W-1:ESPL_W]) * PA_W'(st_mid.sa);
            rt_blo  <= PA_W'(w_q1[ESPL_W-1:0]) * PA_W'(st_mid.sb);
            rt_bhi  <= PA_W'(w_q1[EN_W-1:ESPL_W]) * PA_W'(st_mid.sb);
        end
    end

    // length stage: correction lengths for a and b, connector magnitudes
    t_err             rl_mid;
    logic             rl_corr;
    logic [LEN_W-1:0] rl_la;
    logic [LEN_W-1:0] rl_lb;
    logic [MAG_W-1:0] rl_mcx;
    logic [MAG_W-1:0] rl_mcy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            rl_mid  <= rt_mid;
            rl_corr <= rt_corr;
            rl_la   <= LEN_W'(((PROD_W'(rt_ahi) << ESPL_W) + PROD_W'(rt_alo)) >> FRAC_BITS);
            rl_lb   <= LEN_W'(((PROD_W'(rt_bhi) << ESPL_W) + PROD_W'(rt_blo)) >> FRAC_BITS);
            rl_mcx  <= rt_mid.cx[CON_W-1] ? MAG_W'(-rt_mid.cx) : MAG_W'(rt_mid.cx);
            rl_mcy  <= rt_mid.cy[CON_W-1] ? MAG_W'(-rt_mid.cy) : MAG_W'(rt_mid.cy);
        end
    end

    // product stage: |component| times correction length, in two halves
    // component order: a x, a y, b x, b y
    logic [MAG_W-1:0] sp_mag [NCOMP];
    logic [LEN_W-1:0] sp_len [NCOMP];
    t_err             rp_mid;
    logic             rp_corr;
    logic [PB_W-1:0]  rp_lo [NCOMP];
    logic [PB_W-1:0]  rp_hi [NCOMP];

    always_comb begin
        sp_mag[0] = rl_mcx;
        sp_mag[1] = rl_mcy;
        sp_mag[2] = rl_mcx;
        sp_mag[3] = rl_mcy;
        sp_len[0] = rl_la;
        sp_len[1] = rl_la;
        sp_len[2] = rl_lb;
        sp_len[3] = rl_lb;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rp_mid  <= rl_mid;
            rp_corr <= rl_corr;
            for (int i = 0; i < NCOMP; i++) begin
                rp_lo[i] <= PB_W'(sp_mag[i]) * PB_W'(sp_len[i][LSPL_W-1:0]);
                rp_hi[i] <= PB_W'(sp_mag[i]) * PB_W'(sp_len[i][LEN_W-1:LSPL_W]);
            end
        end
    end

    // numerator stage: full products, signs of each component move
    logic [CN_W-1:0]   rn_num [NCOMP];
    logic [ROOT_W-1:0] rn_den;
    t_fix              rn_fix;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NCOMP; i++) begin
                rn_num[i] <= (CN_W'(rp_hi[i]) << LSPL_W) + CN_W'(rp_lo[i]);
            end
            rn_den      <= rp_mid.root;
            rn_fix.dax  <= rp_mid.dax;
            rn_fix.day  <= rp_mid.day;
            rn_fix.dbx  <= rp_mid.dbx;
            rn_fix.dby  <= rp_mid.dby;
            // a moves against the error, b along it
            rn_fix.neg[0] <= !rp_mid.eneg ^ rp_mid.cx[CON_W-1];
            rn_fix.neg[1] <= !rp_mid.eneg ^ rp_mid.cy[CON_W-1];
            rn_fix.neg[2] <= rp_mid.eneg ^ rp_mid.cx[CON_W-1];
            rn_fix.neg[3] <= rp_mid.eneg ^ rp_mid.cy[CON_W-1];
            rn_fix.corr <= rp_corr;
        end
    end

    // component magnitudes divided by the connector length
    logic [LEN_W-1:0] w_q2 [NCOMP];

    for (genvar i = 0; i < NCOMP; i++) begin : g_comp
        dcp_div #(
            .N_W (CN_W),
            .D_W (ROOT_W),
            .Q_W (LEN_W)
        ) u_div_comp (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (rn_num[i]),
            .i_den (rn_den),
            .o_quo (w_q2[i])
        );
    end

    t_fix r_fix_d [LEN_W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fix_d[0] <= rn_fix;
            for (int k = 1; k < LEN_W; k++) begin
                r_fix_d[k] <= r_fix_d[k-1];
            end
        end
    end

    // final stage: add, clamp to the coordinate range, select pass-through
    t_fix                         sf_fix;
    logic signed [COORD_BITS-1:0] sf_disp [NCOMP];
    logic signed [SUM_W-1:0]      sf_sum  [NCOMP];
    logic signed [SUM_W-1:0]      sf_step [NCOMP];
    logic signed [COORD_BITS-1:0] sf_res  [NCOMP];
    logic signed [COORD_BITS-1:0] r_res   [NCOMP];
    logic                         r_res_corr;

    always_comb begin
        sf_fix     = r_fix_d[LEN_W-1];
        sf_disp[0] = sf_fix.dax;
        sf_disp[1] = sf_fix.day;
        sf_disp[2] = sf_fix.dbx;
        sf_disp[3] = sf_fix.dby;
        for (int i = 0; i < NCOMP; i++) begin
            sf_step[i] = $signed(SUM_W'(w_q2[i]));
            sf_sum[i]  = SUM_W'(sf_disp[i]) + (sf_fix.neg[i] ? -sf_step[i] : sf_step[i]);
            if (!sf_fix.corr) begin
                sf_res[i] = sf_disp[i];
            end else if (sf_sum[i][SUM_W-1:COORD_BITS-1] == '0 ||
                         sf_sum[i][SUM_W-1:COORD_BITS-1] == '1) begin
                sf_res[i] = sf_sum[i][COORD_BITS-1:0];
            end else if (sf_sum[i][SUM_W-1]) begin
                sf_res[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
            end else begin
                sf_res[i] = {1'b0, {(COORD_BITS-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NCOMP; i++) begin
                r_res[i] <= sf_res[i];
            end
            r_res_corr <= sf_fix.corr;
        end
    end

    assign o_res.valid        = r_vld[LAT-1];
    assign o_res.new_disp_a_x = r_res[0];
    assign o_res.new_disp_a_y = r_res[1];
    assign o_res.new_disp_b_x = r_res[2];
    assign o_res.new_disp_b_y = r_res[3];
    assign o_res.corrected    = r_res_corr;

endmodule
